### hdl/dccr_pkg.sv
// Shared types, constants and codes for the DCC packet receiver.
`default_nettype none

package dccr_pkg;

    // Default packet store depth and the number of byte ports on the top level
    localparam int MAX_BYTES_DEFAULT = 6;
    localparam int OUT_BYTES         = 6;

    // Depth of the queue between framing and judging
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEVICE_IS_LOCO = 3'd0;
    localparam logic [2:0] CFG_OWN_ADDRESS    = 3'd1;
    localparam logic [2:0] CFG_ONE_THRESHOLD  = 3'd2;
    localparam logic [2:0] CFG_MIN_PREAMBLE   = 3'd3;
    localparam logic [2:0] CFG_MAX_PREAMBLE   = 3'd4;

    // Configuration reset values
    localparam logic        RST_DEVICE_IS_LOCO = 1'b0;
    localparam logic [13:0] RST_OWN_ADDRESS    = 14'd3;
    localparam logic [15:0] RST_ONE_THRESHOLD  = 16'd100;
    localparam logic [4:0]  RST_MIN_PREAMBLE   = 5'd10;
    localparam logic [4:0]  RST_MAX_PREAMBLE   = 5'd24;

    // Result status codes
    localparam logic [2:0] ST_ACCESSORY      = 3'd0;
    localparam logic [2:0] ST_SHORT_LOCO     = 3'd1;
    localparam logic [2:0] ST_LONG_LOCO      = 3'd2;
    localparam logic [2:0] ST_READ_ERROR     = 3'd3;
    localparam logic [2:0] ST_SHORT_PREAMBLE = 3'd4;
    localparam logic [2:0] ST_REJECTED       = 3'd5;

    // Packet class in the top two bits of the first byte
    localparam logic [7:0] CLASS_MASK       = 8'hC0;
    localparam logic [7:0] CLASS_ACCESSORY  = 8'h80;
    localparam logic [7:0] CLASS_SHORT_LOCO = 8'h00;
    localparam logic [7:0] CLASS_LONG_LOCO  = 8'hC0;

    // Kind of event the framer hands to the judge
    typedef enum logic [1:0] {
        EV_PACKET         = 2'd0,
        EV_READ_ERROR     = 2'd1,
        EV_SHORT_PREAMBLE = 2'd2
    } ev_kind_t;

    // Event summary travelling with the packet bytes
    typedef struct packed {
        ev_kind_t    kind;
        logic [4:0]  preamble_len;
        logic        xor_ok;
    } ev_meta_t;

endpackage

`default_nettype wire

### hdl/dccr_front.sv
// Bit slicer and packet framer: classifies pulses and assembles packets.
`default_nettype none

module dccr_front
    import dccr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT,
    parameter int CW        = $clog2(MAX_BYTES + 1)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [15:0]                   pulse_width_us,
    input  wire logic [15:0]                   one_threshold_us,
    input  wire logic [4:0]                    min_preamble,
    input  wire logic [4:0]                    max_preamble,
    input  wire logic                          q_full,
    output logic                               ev_push,
    output ev_meta_t                           ev_meta,
    output logic [CW-1:0]                      ev_count,
    output logic [MAX_BYTES-1:0][7:0]          ev_bytes
);

    typedef enum logic [2:0] {
        PH_PREAMBLE  = 3'b001,
        PH_DATA      = 3'b010,
        PH_SEPARATOR = 3'b100
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [4:0]                 ones_run_reg, ones_run_next;
    logic [2:0]                 bit_pos_reg, bit_pos_next;
    logic [CW-1:0]              bytes_reg, bytes_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [7:0]                 xor_reg, xor_next;
    logic [MAX_BYTES-1:0][7:0]  store_reg;
    logic [MAX_BYTES-1:0]       byte_we;

    logic       accept;
    logic       bit_val;
    logic [7:0] new_byte;
    logic [5:0] ones_inc;
    logic [4:0] ones_sat;

    // Hold input while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign bit_val  = pulse_width_us < one_threshold_us;
    assign new_byte = {shift_reg[6:0], bit_val};
    assign ones_inc = {1'b0, ones_run_reg} + 6'd1;
    assign ones_sat = ones_inc[5] ? 5'd31 : ones_inc[4:0];
    assign ev_bytes = store_reg;

    // Framing state machine
    always_comb
    begin
        phase_next    = phase_reg;
        ones_run_next = ones_run_reg;
        bit_pos_next  = bit_pos_reg;
        bytes_next    = bytes_reg;
        shift_next    = shift_reg;
        xor_next      = xor_reg;
        byte_we       = '0;
        ev_push       = 1'b0;
        ev_meta.kind         = EV_PACKET;
        ev_meta.preamble_len = ones_run_reg;
        ev_meta.xor_ok       = (xor_reg == 8'd0);
        ev_count      = bytes_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (bit_pos_reg == 3'd7)
                    begin
                        for (int k = 0; k < MAX_BYTES; k++)
                        begin
                            if (int'(bytes_reg) == k)
                            begin
                                byte_we[k] = 1'b1;
                            end
                        end
                        bytes_next   = bytes_reg + CW'(1);
                        xor_next     = xor_reg ^ new_byte;
                        bit_pos_next = 3'd0;
                        shift_next   = new_byte;
                        phase_next   = PH_SEPARATOR;
                    end
                    else
                    begin
                        shift_next   = new_byte;
                        bit_pos_next = bit_pos_reg + 3'd1;
                    end
                end
                PH_SEPARATOR:
                begin
                    if (!bit_val && (int'(bytes_reg) < MAX_BYTES))
                    begin
                        // another byte follows
                        shift_next   = 8'd0;
                        bit_pos_next = 3'd0;
                        phase_next   = PH_DATA;
                    end
                    else
                    begin
                        // end bit, or one byte too many
                        ev_push      = 1'b1;
                        ev_meta.kind = bit_val ? EV_PACKET : EV_READ_ERROR;
                        phase_next    = PH_PREAMBLE;
                        ones_run_next = 5'd0;
                        bit_pos_next  = 3'd0;
                        bytes_next    = '0;
                        shift_next    = 8'd0;
                        xor_next      = 8'd0;
                    end
                end
                default:
                begin
                    if (bit_val)
                    begin
                        if (ones_run_reg >= max_preamble)
                        begin
                            // preamble too long
                            ev_push              = 1'b1;
                            ev_meta.kind         = EV_READ_ERROR;
                            ev_meta.preamble_len = ones_sat;
                            ev_count             = '0;
                            ones_run_next        = 5'd0;
                        end
                        else
                        begin
                            ones_run_next = ones_inc[4:0];
                        end
                        phase_next = PH_PREAMBLE;
                    end
                    else if (ones_run_reg < min_preamble)
                    begin
                        // start bit came too early
                        ev_push       = 1'b1;
                        ev_meta.kind  = EV_SHORT_PREAMBLE;
                        ev_count      = '0;
                        ones_run_next = 5'd0;
                        phase_next    = PH_PREAMBLE;
                    end
                    else
                    begin
                        phase_next   = PH_DATA;
                        bit_pos_next = 3'd0;
                        bytes_next   = '0;
                        shift_next   = 8'd0;
                        xor_next     = 8'd0;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREAMBLE;
            ones_run_reg <= 5'd0;
            bit_pos_reg  <= 3'd0;
            bytes_reg    <= '0;
            shift_reg    <= 8'd0;
            xor_reg      <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ones_run_reg <= ones_run_next;
            bit_pos_reg  <= bit_pos_next;
            bytes_reg    <= bytes_next;
            shift_reg    <= shift_next;
            xor_reg      <= xor_next;
        end
    end

    // Packet byte store
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            if (byte_we[k])
            begin
                store_reg[k] <= new_byte;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/dccr_queue.sv
// Small FIFO that decouples the framer from the packet judge.
`default_nettype none

module dccr_queue
    import dccr_pkg::*;
#(
    parameter int DW = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output logic [DW-1:0]      head_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]  mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_pop;

    assign full       = (int'(count_reg) == QUEUE_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (int'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (int'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/dccr_back.sv
// Packet judge: checksum, class and address match, and the output register.
`default_nettype none

module dccr_back
    import dccr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT,
    parameter int CW        = $clog2(MAX_BYTES + 1)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          device_is_locomotive,
    input  wire logic [13:0]                   own_address,
    input  wire logic                          head_valid,
    input  wire ev_meta_t                      head_meta,
    input  wire logic [CW-1:0]                 head_count,
    input  wire logic [MAX_BYTES-1:0][7:0]     head_bytes,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [2:0]                         packet_length,
    output logic [4:0]                         preamble_length,
    output logic [OUT_BYTES-1:0][7:0]          out_bytes
);

    localparam int NPAD = (MAX_BYTES > OUT_BYTES) ? MAX_BYTES : OUT_BYTES;

    logic                      out_valid_reg;
    logic [2:0]                status_reg, status_next;
    logic [2:0]                length_reg, length_next;
    logic [4:0]                preamble_reg;
    logic [OUT_BYTES-1:0][7:0] bytes_reg, bytes_next;

    logic [NPAD-1:0][7:0] padded;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           cls;
    logic [13:0]          acc_addr;
    logic [13:0]          short_addr;
    logic [13:0]          long_addr;
    logic [2:0]           packet_status;

    assign padded = (NPAD * 8)'(head_bytes);
    assign b0     = head_bytes[0];
    assign b1     = head_bytes[1];
    assign cls    = b0 & CLASS_MASK;

    // Decode the three address layouts
    always_comb
    begin
        if (b1[7])
        begin
            acc_addr = {5'd0, b1[4], b1[5], b1[6], b0[5:0]};
        end
        else
        begin
            acc_addr = {3'd0, b1[4], b1[5], b1[6], b0[5:0], b1[2], b1[1]};
        end
        short_addr = {7'd0, b0[6:0]};
        long_addr  = {b0[5:0], b1};
    end

    // Judge a finished packet
    always_comb
    begin
        packet_status = ST_REJECTED;
        if ((head_count >= CW'(2)) && head_meta.xor_ok)
        begin
            if (cls == CLASS_ACCESSORY)
            begin
                if (!device_is_locomotive && (acc_addr == own_address))
                begin
                    packet_status = ST_ACCESSORY;
                end
            end
            else if (device_is_locomotive)
            begin
                if ((cls == CLASS_SHORT_LOCO) && (short_addr == own_address))
                begin
                    packet_status = ST_SHORT_LOCO;
                end
                else if ((cls == CLASS_LONG_LOCO) && (long_addr == own_address))
                begin
                    packet_status = ST_LONG_LOCO;
                end
            end
        end
    end

    // Build the result fields
    always_comb
    begin
        case (head_meta.kind)
            EV_PACKET:         status_next = packet_status;
            EV_SHORT_PREAMBLE: status_next = ST_SHORT_PREAMBLE;
            default:           status_next = ST_READ_ERROR;
        endcase
        length_next = (int'(head_count) > 7) ? 3'd7 : 3'(head_count);
        for (int k = 0; k < OUT_BYTES; k++)
        begin
            bytes_next[k] = (k < int'(head_count)) ? padded[k] : 8'd0;
        end
    end

    // Load the output register when it is empty or its transaction completes
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg   <= status_next;
            length_reg   <= length_next;
            preamble_reg <= head_meta.preamble_len;
            bytes_reg    <= bytes_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign packet_length   = length_reg;
    assign preamble_length = preamble_reg;
    assign out_bytes       = bytes_reg;

endmodule

`default_nettype wire

### hdl/dcc_packet_receiver.sv
// DCC packet receiver top level: configuration registers, framer, queue and judge.
//
// Input channel: one measured high-pulse width per transaction on
// pulse_width_us (in_valid / in_stall). Widths below one_threshold_us are
// ones. Output channel: one result per finished packet or framing error
// (out_valid / out_stall), carrying status, lengths and up to six bytes.
// Bits that do not end a packet or raise an error give no result.
// Configuration: cfg_write with cfg_index / cfg_data, written while idle.
// Throughput: one pulse per cycle while in_stall is low. The framer takes
// each accepted bit and pushes any result into a two-entry queue; the judge
// checks checksum, class and address combinationally into the output register.
// A result is written into the queue by the bit that ends the packet, then
// into the output register when it is free, and is shown with out_valid high.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_stall rises once both queue entries are taken.
// Reset clears the framer to the preamble phase, empties the queue and
// output register, and loads the configuration reset values. The packet
// byte store has no reset; only bytes written for the current packet are shown.
`default_nettype none

module dcc_packet_receiver
    import dccr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] pulse_width_us,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [2:0]       packet_length,
    output logic [4:0]       preamble_length,
    output logic [7:0]       byte_zero,
    output logic [7:0]       byte_one,
    output logic [7:0]       byte_two,
    output logic [7:0]       byte_three,
    output logic [7:0]       byte_four,
    output logic [7:0]       byte_five
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int QW = $bits(ev_meta_t) + CW + 8 * MAX_BYTES;

    logic        loco_reg;
    logic [13:0] address_reg;
    logic [15:0] threshold_reg;
    logic [4:0]  min_pre_reg;
    logic [4:0]  max_pre_reg;

    logic                      q_full;
    logic                      ev_push;
    ev_meta_t                  ev_meta;
    logic [CW-1:0]             ev_count;
    logic [MAX_BYTES-1:0][7:0] ev_bytes;
    logic                      pop;
    logic                      head_valid;
    logic [QW-1:0]             head_data;
    ev_meta_t                  head_meta;
    logic [CW-1:0]             head_count;
    logic [MAX_BYTES-1:0][7:0] head_bytes;
    logic [OUT_BYTES-1:0][7:0] out_bytes;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_reg      <= RST_DEVICE_IS_LOCO;
            address_reg   <= RST_OWN_ADDRESS;
            threshold_reg <= RST_ONE_THRESHOLD;
            min_pre_reg   <= RST_MIN_PREAMBLE;
            max_pre_reg   <= RST_MAX_PREAMBLE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEVICE_IS_LOCO: loco_reg      <= cfg_data[0];
                CFG_OWN_ADDRESS:    address_reg   <= cfg_data[13:0];
                CFG_ONE_THRESHOLD:  threshold_reg <= cfg_data;
                CFG_MIN_PREAMBLE:   min_pre_reg   <= cfg_data[4:0];
                CFG_MAX_PREAMBLE:   max_pre_reg   <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    dccr_front #(
        .MAX_BYTES (MAX_BYTES),
        .CW        (CW)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pulse_width_us   (pulse_width_us),
        .one_threshold_us (threshold_reg),
        .min_preamble     (min_pre_reg),
        .max_preamble     (max_pre_reg),
        .q_full           (q_full),
        .ev_push          (ev_push),
        .ev_meta          (ev_meta),
        .ev_count         (ev_count),
        .ev_bytes         (ev_bytes)
    );

    dccr_queue #(
        .DW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ev_push),
        .push_data  ({ev_meta, ev_count, ev_bytes}),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_meta, head_count, head_bytes} = head_data;

    dccr_back #(
        .MAX_BYTES (MAX_BYTES),
        .CW        (CW)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .device_is_locomotive (loco_reg),
        .own_address          (address_reg),
        .head_valid           (head_valid),
        .head_meta            (head_meta),
        .head_count           (head_count),
        .head_bytes           (head_bytes),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .packet_length        (packet_length),
        .preamble_length      (preamble_length),
        .out_bytes            (out_bytes)
    );

    assign byte_zero  = out_bytes[0];
    assign byte_one   = out_bytes[1];
    assign byte_two   = out_bytes[2];
    assign byte_three = out_bytes[3];
    assign byte_four  = out_bytes[4];
    assign byte_five  = out_bytes[5];

endmodule

`default_nettype wire
